// File: rtl/bounded_deque_with_search_unit_defines.svh
// assertion macros used by the top-level rtl file
`ifndef BOUNDED_DEQUE_WITH_SEARCH_UNIT_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define BDQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define BDQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define BDQ_ASSERT_IMP(label, clk, rst, ante, cons)
`define BDQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/bdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

   localparam int CAPACITY   = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);

   typedef logic [DATA_WIDTH-1:0] data_type;
   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [CNT_W-1:0]      count_type;
   typedef logic [CAPACITY-1:0]   hit_type;

   // command codes
   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_COUNT      = 3'd4;
   localparam logic [2:0] OP_FIND       = 3'd5;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // per-cell move control
   typedef struct packed {
      logic load;       // take the command word
      logic take_prev;  // take the neighbor toward the front
      logic take_next;  // take the neighbor toward the back
   } bdq_cell_ctl_type;

endpackage

`default_nettype wire

// File: rtl/bdq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module bdq_cell (
   input  wire                      clock,
   input  wire bdq_pkg::bdq_cell_ctl_type ctl,
   input  wire bdq_pkg::data_type   load_data,
   input  wire bdq_pkg::data_type   prev_data,
   input  wire bdq_pkg::data_type   next_data,
   input  wire bdq_pkg::data_type   key,
   input  wire                      live,
   output bdq_pkg::data_type        data,
   output logic                     hit
);
   import bdq_pkg::*;

   data_type data_ff;
   data_type data_in;

   always_comb begin
      if (ctl.load) begin
         data_in = load_data;
      end else if (ctl.take_prev) begin
         data_in = prev_data;
      end else if (ctl.take_next) begin
         data_in = next_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
   // only live cells may match the search key
   assign hit  = live && (data_ff == key);

endmodule

`default_nettype wire

// File: rtl/bdq_first_hit.sv
`timescale 1ns / 1ps
`default_nettype none

module bdq_first_hit (
   input  wire bdq_pkg::hit_type hits,
   output logic                  any,
   output bdq_pkg::idx_type      idx
);
   import bdq_pkg::*;

   hit_type lowest;

   // isolate the lowest set bit, then encode the one-hot vector
   assign lowest = hits & (~hits + hit_type'(1));
   assign any    = |hits;

   always_comb begin
      idx = '0;
      for (int b = 0; b < IDX_W; b++) begin
         for (int i = 0; i < CAPACITY; i++) begin
            if (((i >> b) & 1) == 1) begin
               idx[b] = idx[b] | lowest[i];
            end
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/bounded_deque_with_search_unit.sv
`timescale 1ns / 1ps
`default_nettype none
//
// channel  | direction | handshake           | payload
// ---------+-----------+---------------------+------------------------------------------
// req      | in        | req_valid/req_ready | operation, value
// rsp      | out       | rsp_valid/rsp_ready | result_value, status, found, position,
//          |           |                     | element_count
//
// each item is captured in S_IDLE, then run on the row of cells in S_EXEC, which loads
// the result register
// find compares the key against every cell at once and picks the lowest live hit
// synchronous reset empties the sequence; cell contents are left as they are
// a new item is taken while a result waits; the execute cycle holds off until
// the result register is free
//
`include "bounded_deque_with_search_unit_defines.svh"

module bounded_deque_with_search_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [2:0]  req_operation,
   input  wire  [31:0] req_value,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [31:0] rsp_result_value,
   output logic [1:0]  rsp_status,
   output logic        rsp_found,
   output logic [3:0]  rsp_position,
   output logic [4:0]  rsp_element_count
);
   import bdq_pkg::*;

   typedef enum logic {S_IDLE, S_EXEC} state_type;

   state_type state_ff;
   logic [2:0] op_ff;
   data_type   word_ff;
   count_type  count_ff;
   count_type  count_in;

   logic        rsp_valid_ff;
   logic [31:0] rsp_value_ff;
   logic [1:0]  rsp_status_ff;
   logic        rsp_found_ff;
   logic [3:0]  rsp_position_ff;
   logic [4:0]  rsp_count_ff;

   logic [31:0] res_value;
   logic [1:0]  res_status;
   logic        res_found;
   logic [3:0]  res_position;

   logic out_free;
   logic exec_go;
   logic is_full;
   logic is_empty;

   bdq_cell_ctl_type ctl [CAPACITY];
   data_type         cell_data [CAPACITY];
   data_type         prev_data [CAPACITY];
   data_type         next_data [CAPACITY];
   logic             live [CAPACITY];
   hit_type          hits;
   logic             any_hit;
   idx_type          hit_idx;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign exec_go  = (state_ff == S_EXEC) && out_free;
   assign is_full  = (count_ff == count_type'(CAPACITY));
   assign is_empty = (count_ff == '0);

   // cell row: front element sits in cell 0, live cells are 0 .. count-1
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      assign live[g] = (count_type'(g) < count_ff);

      if (g == 0) begin : g_head
         assign prev_data[g] = word_ff;
      end else begin : g_mid_prev
         assign prev_data[g] = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
         assign next_data[g] = cell_data[g];
      end else begin : g_mid_next
         assign next_data[g] = cell_data[g+1];
      end

      always_comb begin
         ctl[g] = '0;
         if (exec_go) begin
            unique case (op_ff)
               OP_PUSH_FRONT: begin
                  if (!is_full) begin
                     ctl[g].load      = (g == 0);
                     ctl[g].take_prev = (g != 0);
                  end
               end
               OP_PUSH_BACK: begin
                  if (!is_full) begin
                     ctl[g].load = (count_type'(g) == count_ff);
                  end
               end
               OP_POP_FRONT: begin
                  if (!is_empty) begin
                     ctl[g].take_next = 1'b1;
                  end
               end
               default: begin
                  ctl[g] = '0;
               end
            endcase
         end
      end

      bdq_cell u_cell (
         .clock     (clock),
         .ctl       (ctl[g]),
         .load_data (word_ff),
         .prev_data (prev_data[g]),
         .next_data (next_data[g]),
         .key       (word_ff),
         .live      (live[g]),
         .data      (cell_data[g]),
         .hit       (hits[g])
      );
   end

   bdq_first_hit u_first_hit (
      .hits (hits),
      .any  (any_hit),
      .idx  (hit_idx)
   );

   // result and next count for the command in flight
   always_comb begin
      res_value    = '0;
      res_status   = ST_OK;
      res_found    = 1'b0;
      res_position = '0;
      count_in     = count_ff;
      unique case (op_ff) inside
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (is_full) begin
               res_status = ST_FULL;
            end else begin
               count_in = count_ff + count_type'(1);
            end
         end
         OP_POP_FRONT: begin
            if (is_empty) begin
               res_status = ST_EMPTY;
            end else begin
               res_value = 32'(cell_data[0]);
               count_in  = count_ff - count_type'(1);
            end
         end
         OP_POP_BACK: begin
            if (is_empty) begin
               res_status = ST_EMPTY;
            end else begin
               res_value = 32'(cell_data[idx_type'(count_ff - count_type'(1))]);
               count_in  = count_ff - count_type'(1);
            end
         end
         OP_FIND: begin
            res_found    = any_hit;
            res_position = any_hit ? 4'(hit_idx) : 4'd0;
         end
         default: begin
            // count and unused codes leave everything as is
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a result loaded this cycle takes over the valid flag
         if (rsp_valid_ff && rsp_ready && !exec_go) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff    <= req_operation;
                  word_ff  <= data_type'(req_value);
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (out_free) begin
                  count_ff        <= count_in;
                  rsp_value_ff    <= res_value;
                  rsp_status_ff   <= res_status;
                  rsp_found_ff    <= res_found;
                  rsp_position_ff <= res_position;
                  rsp_count_ff    <= 5'(count_in);
                  rsp_valid_ff    <= 1'b1;
                  state_ff        <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_value  = rsp_value_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_position      = rsp_position_ff;
   assign rsp_element_count = rsp_count_ff;

   // occupancy never passes the capacity
   `BDQ_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= count_type'(CAPACITY))
   // a full flag only comes with a full sequence
   `BDQ_ASSERT_IMP(a_full_flag, clock, reset, rsp_valid_ff && (rsp_status_ff == ST_FULL),
      rsp_count_ff == 5'(CAPACITY))
   // an empty flag only comes with an empty sequence and no data
   `BDQ_ASSERT_IMP(a_empty_flag, clock, reset, rsp_valid_ff && (rsp_status_ff == ST_EMPTY),
      (rsp_count_ff == 5'd0) && (rsp_value_ff == 32'd0))
   // a match lies inside the live part of the sequence
   `BDQ_ASSERT_IMP(a_found_pos, clock, reset, rsp_valid_ff && rsp_found_ff,
      5'(rsp_position_ff) < rsp_count_ff)
   // a command that runs leaves a result behind
   `BDQ_ASSERT_NEXT(a_exec_result, clock, reset, exec_go, rsp_valid_ff && (state_ff == S_IDLE))

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import bdq_pkg::*;

   // codes the block leaves unused
   localparam logic [2:0] OP_UNUSED_6 = 3'd6;
   localparam logic [2:0] OP_UNUSED_7 = 3'd7;

   localparam int QUIET_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 20;
   localparam int PHASE_ITEMS = 450;

   typedef struct packed {
      data_type     value;
      logic [1:0]   status;
      logic         found;
      logic [3:0]   position;
      logic [4:0]   count;
   } deque_result_type;

   // ring model of the sequence plus the results it still owes
   class deque_scoreboard;
      data_type         ring [CAPACITY];
      int unsigned      head;
      int unsigned      live;
      int unsigned      errors;
      deque_result_type owed [$];

      function new();
         head = 0;
         live = 0;
         errors = 0;
      endfunction

      function int unsigned slot(int unsigned offset);
         return (head + offset) % CAPACITY;
      endfunction

      function data_type pick_live();
         return ring[slot($urandom_range(live - 1))];
      endfunction

      function void note_command(logic [2:0] op, logic [31:0] word);
         deque_result_type want;
         data_type key;
         want = '0;
         key = data_type'(word);
         case (op)
            OP_PUSH_FRONT: begin
               if (live >= CAPACITY) begin
                  want.status = ST_FULL;
               end else begin
                  head = slot(CAPACITY - 1);
                  ring[head] = key;
                  live++;
               end
            end
            OP_PUSH_BACK: begin
               if (live >= CAPACITY) begin
                  want.status = ST_FULL;
               end else begin
                  ring[slot(live)] = key;
                  live++;
               end
            end
            OP_POP_FRONT: begin
               if (live == 0) begin
                  want.status = ST_EMPTY;
               end else begin
                  want.value = ring[head];
                  head = slot(1);
                  live--;
               end
            end
            OP_POP_BACK: begin
               if (live == 0) begin
                  want.status = ST_EMPTY;
               end else begin
                  want.value = ring[slot(live - 1)];
                  live--;
               end
            end
            OP_FIND: begin
               // first match counted from the front
               for (int i = 0; i < live; i++) begin
                  if (!want.found && ring[slot(i)] == key) begin
                     want.found = 1'b1;
                     want.position = 4'(i);
                  end
               end
            end
            default: ;
         endcase
         want.count = 5'(live);
         owed.push_back(want);
      endfunction

      task report(string what);
         $display("%0t mismatch: %s", $time, what);
         errors++;
      endtask

      task check_result(deque_result_type got);
         deque_result_type want;
         if (owed.size() == 0) begin
            report("result with no command outstanding");
         end else begin
            want = owed.pop_front();
            if (got.value !== want.value)
               report($sformatf("result_value got %h want %h", got.value, want.value));
            if (got.status !== want.status)
               report($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.found !== want.found)
               report($sformatf("found got %b want %b", got.found, want.found));
            if (got.position !== want.position)
               report($sformatf("position got %0d want %0d", got.position, want.position));
            if (got.count !== want.count)
               report($sformatf("element_count got %0d want %0d", got.count, want.count));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_operation;
   logic [31:0] req_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_result_value;
   logic [1:0]  rsp_status;
   logic        rsp_found;
   logic [3:0]  rsp_position;
   logic [4:0]  rsp_element_count;

   deque_scoreboard sb;
   int unsigned     send_gap_pct;
   int unsigned     stall_pct;
   int unsigned     quiet_cycles;
   bit              filling;

   bounded_deque_with_search_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_value  (rsp_result_value),
      .rsp_status        (rsp_status),
      .rsp_found         (rsp_found),
      .rsp_position      (rsp_position),
      .rsp_element_count (rsp_element_count)
   );

   always #5 clock = ~clock;

   // receiver backpressure, changed on the falling edge
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result({rsp_result_value, rsp_status, rsp_found, rsp_position,
                          rsp_element_count});
   end

   // ends a run in which neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task send_command(logic [2:0] op, logic [31:0] word);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_value     <= word;
      do @(posedge clock); while (!req_ready);
      sb.note_command(op, word);
      @(negedge clock);
   endtask

   // drift toward full while filling and toward empty while draining
   function logic [2:0] choose_op();
      int unsigned r;
      r = $urandom_range(99);
      if (sb.live >= CAPACITY) filling = 1'b0;
      else if (sb.live == 0) filling = 1'b1;
      else if ($urandom_range(99) < 2) filling = !filling;
      if (filling) begin
         if (r < 35) return OP_PUSH_BACK;
         if (r < 60) return OP_PUSH_FRONT;
         if (r < 68) return OP_POP_FRONT;
         if (r < 76) return OP_POP_BACK;
         if (r < 92) return OP_FIND;
      end else begin
         if (r < 8)  return OP_PUSH_BACK;
         if (r < 16) return OP_PUSH_FRONT;
         if (r < 41) return OP_POP_FRONT;
         if (r < 66) return OP_POP_BACK;
         if (r < 88) return OP_FIND;
      end
      if (r < 95) return OP_COUNT;
      return ($urandom_range(1) != 0) ? OP_UNUSED_7 : OP_UNUSED_6;
   endfunction

   // small pool of words makes duplicates, so first-match order gets exercised
   function logic [31:0] choose_value(logic [2:0] op);
      int unsigned r;
      r = $urandom_range(99);
      if (op == OP_FIND && sb.live > 0 && r < 60) return 32'(sb.pick_live());
      if (r < 80 && r >= 40) return 32'($urandom_range(7));
      return $urandom;
   endfunction

   task run_phase(int unsigned gap, int unsigned stall);
      logic [2:0] op;
      send_gap_pct = gap;
      stall_pct = stall;
      repeat (PHASE_ITEMS) begin
         op = choose_op();
         send_command(op, choose_value(op));
      end
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_COUNT;
      req_value = '0;
      send_gap_pct = 0;
      stall_pct = 0;
      filling = 1'b1;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty sequence: pops flag empty, find misses, unused codes do nothing
      send_command(OP_POP_FRONT, 32'h0);
      send_command(OP_POP_BACK, 32'hFFFF_FFFF);
      send_command(OP_FIND, 32'h0);
      send_command(OP_COUNT, 32'hFFFF_FFFF);
      send_command(OP_UNUSED_6, 32'h1234_5678);
      send_command(OP_UNUSED_7, 32'h0);

      // fill to capacity from both ends, value 0 twice
      for (int i = 0; i < CAPACITY; i++) begin
         logic [31:0] word;
         case (i)
            0:       word = 32'h0;
            1:       word = 32'hFFFF_FFFF;
            2:       word = 32'hAAAA_AAAA;
            3:       word = 32'h5555_5555;
            4:       word = 32'h0;
            default: word = 32'h0100_0001 * i;
         endcase
         send_command(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT, word);
      end

      // full: pushes dropped, find at the far end and first of duplicates
      send_command(OP_PUSH_FRONT, 32'hDEAD_BEEF);
      send_command(OP_PUSH_BACK, 32'hFFFF_FFFF);
      send_command(OP_FIND, 32'h0100_0001 * (CAPACITY - 1));
      send_command(OP_FIND, 32'h0);
      send_command(OP_POP_FRONT, 32'h0);
      send_command(OP_POP_BACK, 32'h0);

      run_phase(0, 0);
      run_phase(45, 0);
      run_phase(0, 45);
      run_phase(23, 23);
      req_valid <= 1'b0;

      while (sb.owed.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/bdq_pkg.sv
rtl/bdq_cell.sv
rtl/bdq_first_hit.sv
rtl/bounded_deque_with_search_unit.sv
tb/testbench.sv
